// ----- rtl/core/ftint_pkg.sv -----
// shared types and constants for the frost tint and highlight pixel block
package ftint_pkg;

    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned ROW_CMP_W  = 13;

    localparam logic [8:0]  WEIGHT_FULL = 9'd256;
    localparam logic [7:0]  LUMA_R      = 8'd54;
    localparam logic [7:0]  LUMA_G      = 8'd183;
    localparam logic [7:0]  LUMA_B      = 8'd19;
    localparam logic [31:0] OPAQUE_WHITE = 32'hFFFF_FFFF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    localparam logic [8:0]  WEIGHT_RST = 9'd64;
    localparam logic [15:0] THRESH_RST = 16'd49613;
    localparam logic [9:0]  TOP_RST    = 10'd0;
    localparam logic [9:0]  THICK_RST  = 10'd5;

    typedef enum logic [1:0] {
        CFG_WEIGHT = 2'd0,
        CFG_THRESH = 2'd1,
        CFG_TOP    = 2'd2,
        CFG_THICK  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0]  weight;
        logic [15:0] thresh;
        logic [9:0]  top;
        logic [9:0]  thick;
    } t_cfg;

    // blended pixel between the blend and shade stages
    typedef struct packed {
        logic        pass;
        logic [31:0] sprite;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        in_band;
    } t_mid;

endpackage

// ----- rtl/core/ftint_blend.sv -----
// blend stage: per-channel weighted mix and band check, registered
module ftint_blend
    import ftint_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  t_cfg        i_cfg,
    input  logic [31:0] i_sprite_pixel,
    input  logic [23:0] i_overlay_pixel,
    input  logic [9:0]  i_pixel_row,
    output t_mid        o_mid
);

    t_mid r_mid;
    t_mid n_mid;

    logic [8:0]           w_sat;
    logic [8:0]           w_inv;
    logic [ROW_CMP_W-1:0] band_sum;
    logic [ROW_CMP_W-1:0] band_end;
    logic [ROW_CMP_W-1:0] row_ext;
    logic [ROW_CMP_W-1:0] top_ext;

    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] o,
                                       input logic [8:0] w, input logic [8:0] wi);
        logic [16:0] acc;
        acc = 17'({9'd0, s} * {8'd0, w}) + 17'({9'd0, o} * {8'd0, wi});
        return acc[15:8];
    endfunction

    always_comb begin
        w_sat    = (i_cfg.weight > WEIGHT_FULL) ? WEIGHT_FULL : i_cfg.weight;
        w_inv    = WEIGHT_FULL - w_sat;
        row_ext  = ROW_CMP_W'(i_pixel_row);
        top_ext  = ROW_CMP_W'(i_cfg.top);
        band_sum = top_ext + ROW_CMP_W'(i_cfg.thick);
        // inclusive band end stops at the last image row
        band_end = (band_sum > ROW_CMP_W'(MAX_HEIGHT - 1)) ?
                   ROW_CMP_W'(MAX_HEIGHT - 1) : band_sum;

        n_mid.pass    = (i_sprite_pixel[31:24] == 8'd0);
        n_mid.sprite  = i_sprite_pixel;
        n_mid.red     = mix(i_sprite_pixel[23:16], i_overlay_pixel[23:16], w_sat, w_inv);
        n_mid.green   = mix(i_sprite_pixel[15:8], i_overlay_pixel[15:8], w_sat, w_inv);
        n_mid.blue    = mix(i_sprite_pixel[7:0], i_overlay_pixel[7:0], w_sat, w_inv);
        n_mid.in_band = (row_ext < ROW_CMP_W'(MAX_HEIGHT)) && (row_ext >= top_ext) &&
                        (row_ext <= band_end);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid = r_mid;

endmodule

// ----- rtl/core/ftint_shade.sv -----
// shade stage: luminance, threshold test and output pixel, registered
module ftint_shade
    import ftint_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [15:0] i_thresh,
    input  t_mid        i_mid,
    output logic [31:0] o_out_pixel,
    output logic        o_highlighted
);

    logic [31:0] r_pixel;
    logic        r_hl;
    logic [31:0] n_pixel;
    logic        n_hl;
    logic [15:0] luma;

    always_comb begin
        luma = 16'({8'd0, i_mid.red} * {8'd0, LUMA_R})
             + 16'({8'd0, i_mid.green} * {8'd0, LUMA_G})
             + 16'({8'd0, i_mid.blue} * {8'd0, LUMA_B});
        if (i_mid.pass) begin
            n_pixel = i_mid.sprite;
            n_hl    = 1'b0;
        end else if (i_mid.in_band && (luma >= i_thresh)) begin
            n_pixel = OPAQUE_WHITE;
            n_hl    = 1'b1;
        end else begin
            n_pixel = {ALPHA_OPAQUE, i_mid.red, i_mid.green, i_mid.blue};
            n_hl    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pixel <= n_pixel;
            r_hl    <= n_hl;
        end
    end

    assign o_out_pixel   = r_pixel;
    assign o_highlighted = r_hl;

endmodule

// ----- rtl/core/frost_tint_highlight_pixel.sv -----
// top level: config registers, input register and three-stage pixel pipeline
// Takes one pixel per clock when the output side keeps up. Each pixel goes
// through three register stages (input, blend, shade). A pixel taken into the
// input register moves through the blend register into the result register,
// from which its result is offered. The blend multipliers and the
// luminance multipliers sit in separate stages. Each stage holds its word
// while the next one is full, so a stall on the output backs up one stage at a
// time and o_in_stall rises only when all three stages hold a word and the
// output is stalled.
// Configuration writes are taken every cycle and should be made while idle.
module frost_tint_highlight_pixel
    import ftint_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_sprite_pixel,
    input  logic [23:0] i_overlay_pixel,
    input  logic [9:0]  i_pixel_row,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_pixel,
    output logic        o_highlighted
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_mid_valid;
    logic        r_out_valid;
    logic [31:0] r_sprite;
    logic [23:0] r_overlay;
    logic [9:0]  r_row;
    t_mid        mid;
    logic        out_free;
    logic        mid_free;
    logic        in_free;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        mid_free = !r_mid_valid || out_free;
        in_free  = !r_in_valid || mid_free;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight <= WEIGHT_RST;
            r_cfg.thresh <= THRESH_RST;
            r_cfg.top    <= TOP_RST;
            r_cfg.thick  <= THICK_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WEIGHT: r_cfg.weight <= i_cfg_data[8:0];
                CFG_THRESH: r_cfg.thresh <= i_cfg_data;
                CFG_TOP:    r_cfg.top    <= i_cfg_data[9:0];
                CFG_THICK:  r_cfg.thick  <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (mid_free) begin
                r_mid_valid <= r_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_sprite  <= i_sprite_pixel;
            r_overlay <= i_overlay_pixel;
            r_row     <= i_pixel_row;
        end
    end

    ftint_blend u_blend (
        .i_clk           (i_clk),
        .i_load          (mid_free && r_in_valid),
        .i_cfg           (r_cfg),
        .i_sprite_pixel  (r_sprite),
        .i_overlay_pixel (r_overlay),
        .i_pixel_row     (r_row),
        .o_mid           (mid)
    );

    ftint_shade u_shade (
        .i_clk         (i_clk),
        .i_load        (out_free && r_mid_valid),
        .i_thresh      (r_cfg.thresh),
        .i_mid         (mid),
        .o_out_pixel   (o_out_pixel),
        .o_highlighted (o_highlighted)
    );

endmodule
